[design/spdp_pkg.sv]
package spdp_pkg;

  localparam int unsigned MAX_SAMPLES  = 96;
  localparam int unsigned CHUNK_POINTS = 48;

  localparam int unsigned CNT_W      = 16;  // valid counts
  localparam int unsigned PICK_W     = 7;   // picks and target
  localparam int unsigned DIVIDEND_W = CNT_W + PICK_W;
  localparam int unsigned STEP_W     = 5;   // divider step counter

  localparam logic [PICK_W-1:0] MAX_SAMPLES_C  = PICK_W'(MAX_SAMPLES);
  localparam logic [PICK_W-1:0] CHUNK_POINTS_C = PICK_W'(CHUNK_POINTS);
  localparam logic [STEP_W-1:0] DIV_LAST_STEP  = STEP_W'(DIVIDEND_W - 1);
  localparam logic [CNT_W-1:0]  CNT_SAT        = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SEND
  } state_t;

  // Per point header fields that depend only on the pick index and target
  typedef struct packed {
    logic       chunk_number;
    logic [1:0] chunks_in_frame;
    logic [5:0] points_this_chunk;
    logic [6:0] frame_total;
    logic [5:0] slot_in_chunk;
    logic       chunk_last;
    logic       frame_last;
  } hdr_t;

endpackage

[design/spdp_div.sv]
module spdp_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [spdp_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [spdp_pkg::CNT_W-1:0]         divisor,
  output logic                               done,
  output logic [spdp_pkg::DIVIDEND_W-1:0]    quotient
);
  import spdp_pkg::*;

  // Restoring divider, one quotient bit per cycle, MSB first.
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [CNT_W-1:0]        dsr_r, dsr_nxt;
  logic [DIVIDEND_W-1:0]   q_r, q_nxt;
  logic [CNT_W:0]          rem_sh;
  logic [CNT_W+1:0]        diff;
  logic                    ge;

  always_comb begin
    rem_sh = {rem_r, q_r[DIVIDEND_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dsr_r};
    ge     = ~diff[CNT_W+1];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;

    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      q_nxt    = dividend;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      q_nxt    = {q_r[DIVIDEND_W-2:0], ge};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == DIV_LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[design/spdp_hdr.sv]
module spdp_hdr (
  input  logic [spdp_pkg::PICK_W-1:0] picked,
  input  logic [spdp_pkg::PICK_W-1:0] target,
  output spdp_pkg::hdr_t              hdr
);
  import spdp_pkg::*;

  logic              chunk;
  logic [PICK_W-1:0] slot;
  logic [PICK_W-1:0] remain;
  logic [PICK_W-1:0] in_chunk;

  always_comb begin
    chunk    = (picked >= CHUNK_POINTS_C);
    slot     = chunk ? picked - CHUNK_POINTS_C : picked;
    remain   = chunk ? target - CHUNK_POINTS_C : target;
    in_chunk = (remain > CHUNK_POINTS_C) ? CHUNK_POINTS_C : remain;

    hdr.chunk_number      = chunk;
    hdr.chunks_in_frame   = (target > CHUNK_POINTS_C) ? 2'd2 : 2'd1;
    hdr.points_this_chunk = in_chunk[5:0];
    hdr.frame_total       = target;
    hdr.slot_in_chunk     = slot[5:0];
    hdr.chunk_last        = (slot + PICK_W'(1) == in_chunk);
    hdr.frame_last        = (picked + PICK_W'(1) == target);
  end

endmodule

[design/scan_point_decimating_packetizer_top.sv]
// A point that is a pick candidate passes the idle, multiply, divide and send states before it
// appears on out_; the serial divider's 23 steps dominate. Points that cannot be picked skip
// the divide state. A new item is taken only once the sequencer is back in idle; in_tready
// is high only while the sequencer is idle.
// Reset (rst_n low, synchronous): link disabled, no scan open, all counts and frame id
// cleared, output empty.
module scan_point_decimating_packetizer_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: link_enabled
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] announced_valid, [31:16] point_x, [47:32] point_y, [55:48] point_level
  input  logic [55:0] in_tdata,
  // [0] scan_start, [1] point_valid
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,   // scan_end
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] frame_number, [16] chunk_number, [18:17] chunks_in_frame,
  // [24:19] points_this_chunk, [31:25] frame_total, [37:32] slot_in_chunk,
  // [53:38] out_x, [69:54] out_y, [77:70] out_level, [79:78] zero
  output logic [79:0] out_tdata,
  output logic [0:0]  out_tuser,  // [0] chunk_last
  output logic        out_tlast   // frame_last
);
  import spdp_pkg::*;

  // sequencer and scan state
  state_t              state_r, state_nxt;
  logic                link_r, link_nxt;
  logic                open_r, open_nxt;
  logic [CNT_W-1:0]    latched_r, latched_nxt;
  logic [PICK_W-1:0]   target_r, target_nxt;
  logic [CNT_W-1:0]    seen_r, seen_nxt;
  logic [PICK_W-1:0]   picked_r, picked_nxt;
  logic [15:0]         frame_r, frame_nxt;
  logic                hit_r, hit_nxt;

  // the point being worked on
  logic                pt_end_r, pt_end_nxt;
  logic                pt_valid_r, pt_valid_nxt;
  logic [15:0]         pt_x_r, pt_x_nxt;
  logic [15:0]         pt_y_r, pt_y_nxt;
  logic [7:0]          pt_lvl_r, pt_lvl_nxt;

  // output register
  logic                ov_r, ov_nxt;
  logic [79:0]         od_r, od_nxt;
  logic                ou_r, ou_nxt;
  logic                ol_r, ol_nxt;

  logic                in_acc;
  logic                out_free;
  logic                candidate;
  logic                div_start;
  logic                div_done;
  logic [DIVIDEND_W-1:0] div_q;
  logic [DIVIDEND_W-1:0] product;
  logic [15:0]         frame_new;
  hdr_t                hdr;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~ov_r | out_tready;

  // multiply feeding the divider: valid index times target
  assign product   = DIVIDEND_W'(seen_r) * DIVIDEND_W'(target_r);
  assign candidate = open_r & pt_valid_r & (picked_r < target_r) & (latched_r != '0);
  assign div_start = (state_r == ST_MUL) & candidate;
  assign frame_new = (picked_r == '0) ? frame_r + 16'd1 : frame_r;

  spdp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (latched_r),
    .done     (div_done),
    .quotient (div_q)
  );

  spdp_hdr u_hdr (
    .picked (picked_r),
    .target (target_r),
    .hdr    (hdr)
  );

  always_comb begin
    state_nxt    = state_r;
    link_nxt     = link_r;
    open_nxt     = open_r;
    latched_nxt  = latched_r;
    target_nxt   = target_r;
    seen_nxt     = seen_r;
    picked_nxt   = picked_r;
    frame_nxt    = frame_r;
    hit_nxt      = hit_r;
    pt_end_nxt   = pt_end_r;
    pt_valid_nxt = pt_valid_r;
    pt_x_nxt     = pt_x_r;
    pt_y_nxt     = pt_y_r;
    pt_lvl_nxt   = pt_lvl_r;
    ov_nxt       = out_tready ? 1'b0 : ov_r;
    od_nxt       = od_r;
    ou_nxt       = ou_r;
    ol_nxt       = ol_r;

    if (cfg_valid) begin
      link_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pt_end_nxt   = in_tlast;
          pt_valid_nxt = in_tuser[1];
          pt_x_nxt     = in_tdata[31:16];
          pt_y_nxt     = in_tdata[47:32];
          pt_lvl_nxt   = in_tdata[55:48];
          if (in_tuser[0]) begin
            // scan start: latch the announced count and restart the picks
            open_nxt    = link_r;
            latched_nxt = in_tdata[15:0];
            target_nxt  = (in_tdata[15:0] < CNT_W'(MAX_SAMPLES)) ?
                          in_tdata[PICK_W-1:0] : MAX_SAMPLES_C;
            seen_nxt    = '0;
            picked_nxt  = '0;
          end
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        hit_nxt   = 1'b0;
        state_nxt = candidate ? ST_DIV : ST_SEND;
      end
      ST_DIV: begin
        if (div_done) begin
          hit_nxt   = (div_q == DIVIDEND_W'(picked_r));
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        // a pick with the link up waits for room in the output register
        if (!(hit_r && link_r && !out_free)) begin
          if (hit_r) begin
            frame_nxt  = frame_new;
            picked_nxt = picked_r + PICK_W'(1);
            if (link_r) begin
              ov_nxt = 1'b1;
              od_nxt = {2'b00, pt_lvl_r, pt_y_r, pt_x_r, hdr.slot_in_chunk,
                        hdr.frame_total, hdr.points_this_chunk, hdr.chunks_in_frame,
                        hdr.chunk_number, frame_new};
              ou_nxt = hdr.chunk_last;
              ol_nxt = hdr.frame_last;
            end
          end
          if (open_r && pt_valid_r && seen_r != CNT_SAT) begin
            seen_nxt = seen_r + CNT_W'(1);
          end
          if (pt_end_r) begin
            open_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      link_r    <= 1'b0;
      open_r    <= 1'b0;
      latched_r <= '0;
      target_r  <= '0;
      seen_r    <= '0;
      picked_r  <= '0;
      frame_r   <= '0;
      hit_r     <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      link_r    <= link_nxt;
      open_r    <= open_nxt;
      latched_r <= latched_nxt;
      target_r  <= target_nxt;
      seen_r    <= seen_nxt;
      picked_r  <= picked_nxt;
      frame_r   <= frame_nxt;
      hit_r     <= hit_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pt_end_r   <= pt_end_nxt;
    pt_valid_r <= pt_valid_nxt;
    pt_x_r     <= pt_x_nxt;
    pt_y_r     <= pt_y_nxt;
    pt_lvl_r   <= pt_lvl_nxt;
    od_r       <= od_nxt;
    ou_r       <= ou_nxt;
    ol_r       <= ol_nxt;
  end

  assign out_tvalid   = ov_r;
  assign out_tdata    = od_r;
  assign out_tuser[0] = ou_r;
  assign out_tlast    = ol_r;

  // checks
  a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    picked_r <= target_r)
    else $error("picked count beyond target");

  a_div_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide step");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_MUL)
    else $error("accepted item did not enter the sequencer");

  a_frame_last_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[0])
    else $error("frame end not on a chunk end");

endmodule
